/* rtl/rbmm_pkg.sv */
// shared constants, codes and types of the row block matrix multiply
package rbmm_pkg;

    localparam int MAT_SIZE    = 16;
    localparam int IDX_W       = $clog2(MAT_SIZE);
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int STORE_DEPTH = MAT_SIZE * MAT_SIZE;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int SUM_W       = 40;
    localparam int RIU_W       = IDX_W + 1;
    localparam logic [RIU_W-1:0] RIU_RESET = RIU_W'(MAT_SIZE);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 4;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);

    // stream data padded to whole bytes
    localparam int IN_DATA_W  = ((2 * IDX_W + ELEM_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * IDX_W + SUM_W + 7) / 8) * 8;

    localparam logic [1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_REJECT  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [ELEM_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
        logic                    rejected;
    } t_result;

endpackage

/* rtl/row_block_matrix_multiply.sv */
// top level of the row block matrix multiply worker kernel
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata {value,col,row}, tuser kind
//  m_axis    out  tvalid/tready           tdata {sum,out_col,out_row}, tlast, tuser rejected
//  cfg       in   i_cfg_we (no wait)      i_cfg_wdata rows_in_use
//
// loads write one store entry each in the back end; a compute row is paced
// by the single MAC walking 16 x 16 products over one read port per store,
// then passes the registered store read and product before its last column enters the result queue
// a rejected row issues a single reject result; reset is synchronous and clears control only
// a 4-beat command queue and a 4-beat result queue let each side stall alone;
// the MAC pauses at a column boundary while all result slots are taken
module row_block_matrix_multiply (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rbmm_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // row [3:0], col [7:4], value [23:8]
    input  logic [1:0]                      s_axis_tuser,   // kind [1:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rbmm_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // out_row [3:0], out_col [7:4], sum [47:8]
    output logic                            m_axis_tlast,
    output logic                            m_axis_tuser,   // rejected
    input  logic                            i_cfg_we,
    input  logic [rbmm_pkg::RIU_W-1:0]      i_cfg_wdata
);

    rbmm_pkg::t_cmd    cmd;
    logic              cmd_valid;
    logic              cmd_pop;
    rbmm_pkg::t_result res;

    rbmm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_cmd         (cmd),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_pop     (cmd_pop)
    );

    rbmm_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cmd_valid    (cmd_valid),
        .o_cmd_pop      (cmd_pop),
        .o_result       (res),
        .o_result_valid (m_axis_tvalid),
        .i_result_ready (m_axis_tready)
    );

    assign m_axis_tdata = rbmm_pkg::OUT_DATA_W'({res.sum, res.col, res.row});
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.rejected;

endmodule

/* rtl/rbmm_front.sv */
// input side: config register, beat classification and command queue
module rbmm_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [rbmm_pkg::IN_DATA_W-1:0] s_axis_tdata,   // row, col, value
    input  logic [1:0]                   s_axis_tuser,   // kind
    input  logic                         i_cfg_we,
    input  logic [rbmm_pkg::RIU_W-1:0]   i_cfg_wdata,
    output rbmm_pkg::t_cmd               o_cmd,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_pop
);

    rbmm_pkg::t_cmd                   r_q [rbmm_pkg::QUEUE_DEPTH];
    logic [rbmm_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [rbmm_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [rbmm_pkg::QPTR_W:0]        r_count;
    logic [rbmm_pkg::RIU_W-1:0]       r_rows_in_use;

    logic                             accept;
    logic                             keep;
    rbmm_pkg::t_cmd                   n_entry;
    logic [rbmm_pkg::IDX_W-1:0]       in_row;

    assign s_axis_tready = (r_count != (rbmm_pkg::QPTR_W + 1)'(rbmm_pkg::QUEUE_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_row        = s_axis_tdata[rbmm_pkg::IDX_W-1:0];

    always_comb begin
        n_entry.row   = in_row;
        n_entry.col   = s_axis_tdata[2*rbmm_pkg::IDX_W-1:rbmm_pkg::IDX_W];
        n_entry.value = s_axis_tdata[2*rbmm_pkg::IDX_W+rbmm_pkg::ELEM_W-1:2*rbmm_pkg::IDX_W];
        n_entry.op    = rbmm_pkg::OP_LOAD_A;
        keep          = 1'b1;
        case (s_axis_tuser)
            rbmm_pkg::KIND_LOAD_A: begin
                n_entry.op = rbmm_pkg::OP_LOAD_A;
            end
            rbmm_pkg::KIND_LOAD_B: begin
                n_entry.op = rbmm_pkg::OP_LOAD_B;
            end
            rbmm_pkg::KIND_COMPUTE: begin
                // rows at or past rows_in_use get a single reject result
                if ({1'b0, in_row} >= r_rows_in_use) begin
                    n_entry.op = rbmm_pkg::OP_REJECT;
                end else begin
                    n_entry.op = rbmm_pkg::OP_COMPUTE;
                end
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= rbmm_pkg::RIU_RESET;
        end else if (i_cfg_we) begin
            r_rows_in_use <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_q[r_wr_ptr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept && keep) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + {{rbmm_pkg::QPTR_W{1'b0}}, (accept && keep)}
                               - {{rbmm_pkg::QPTR_W{1'b0}}, i_cmd_pop};
        end
    end

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

endmodule

/* rtl/rbmm_engine.sv */
// back side: A and B stores, one MAC pipeline and the result queue
module rbmm_engine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rbmm_pkg::t_cmd        i_cmd,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_pop,
    output rbmm_pkg::t_result     o_result,
    output logic                  o_result_valid,
    input  logic                  i_result_ready
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    typedef struct packed {
        logic                       valid;
        logic                       first;
        logic                       lastk;
        logic                       reject;
        logic [rbmm_pkg::IDX_W-1:0] row;
        logic [rbmm_pkg::IDX_W-1:0] col;
    } t_tag;

    localparam logic [rbmm_pkg::IDX_W-1:0] IDX_MAX = rbmm_pkg::IDX_W'(rbmm_pkg::MAT_SIZE - 1);
    localparam logic [rbmm_pkg::OPTR_W:0]  OCNT_FULL = (rbmm_pkg::OPTR_W + 1)'(rbmm_pkg::OUT_DEPTH);

    logic [rbmm_pkg::ELEM_W-1:0] r_a_mem [rbmm_pkg::STORE_DEPTH];
    logic [rbmm_pkg::ELEM_W-1:0] r_b_mem [rbmm_pkg::STORE_DEPTH];

    t_state                          r_state, n_state;
    logic [rbmm_pkg::IDX_W-1:0]      r_row, n_row;
    logic [rbmm_pkg::IDX_W-1:0]      r_k, n_k;
    logic [rbmm_pkg::IDX_W-1:0]      r_j, n_j;
    logic [rbmm_pkg::OPTR_W:0]       r_pend;
    t_tag                            r_s1, r_s2, n_tag;
    logic signed [rbmm_pkg::ELEM_W-1:0] r_rd_a, r_rd_b;
    logic signed [rbmm_pkg::PROD_W-1:0] r_prod;
    logic signed [rbmm_pkg::SUM_W-1:0]  r_acc, n_acc;

    rbmm_pkg::t_result               r_ofifo [rbmm_pkg::OUT_DEPTH];
    logic [rbmm_pkg::OPTR_W-1:0]     r_owr, r_ord;
    logic [rbmm_pkg::OPTR_W:0]       r_ocnt;

    logic                            issue;
    logic                            reserve;
    logic                            can_reserve;
    logic                            we_a, we_b;
    logic [rbmm_pkg::ADDR_W-1:0]     addr_a, addr_b;
    logic                            push;
    logic                            out_pop;
    rbmm_pkg::t_result               n_res;

    assign can_reserve = (r_pend != OCNT_FULL);

    // front of the back end: load writes, command dispatch, MAC issue
    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_k       = r_k;
        n_j       = r_j;
        o_cmd_pop = 1'b0;
        we_a      = 1'b0;
        we_b      = 1'b0;
        issue     = 1'b0;
        n_tag     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        rbmm_pkg::OP_LOAD_A: begin
                            o_cmd_pop = 1'b1;
                            we_a      = 1'b1;
                        end
                        rbmm_pkg::OP_LOAD_B: begin
                            o_cmd_pop = 1'b1;
                            we_b      = 1'b1;
                        end
                        rbmm_pkg::OP_COMPUTE: begin
                            o_cmd_pop = 1'b1;
                            n_row     = i_cmd.row;
                            n_k       = '0;
                            n_j       = '0;
                            n_state   = ST_RUN;
                        end
                        rbmm_pkg::OP_REJECT: begin
                            if (can_reserve) begin
                                o_cmd_pop    = 1'b1;
                                issue        = 1'b1;
                                n_tag.valid  = 1'b1;
                                n_tag.first  = 1'b1;
                                n_tag.lastk  = 1'b1;
                                n_tag.reject = 1'b1;
                                n_tag.row    = i_cmd.row;
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                // a column starts only once a result slot is reserved for it
                if (r_k != '0 || can_reserve) begin
                    issue       = 1'b1;
                    n_tag.valid = 1'b1;
                    n_tag.first = (r_k == '0);
                    n_tag.lastk = (r_k == IDX_MAX);
                    n_tag.row   = r_row;
                    n_tag.col   = r_j;
                    n_k         = r_k + 1'b1;
                    if (r_k == IDX_MAX) begin
                        n_j = r_j + 1'b1;
                        if (r_j == IDX_MAX) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign reserve = issue && n_tag.first;
    assign addr_a  = (r_state == ST_RUN) ? {r_row, r_k} : {i_cmd.row, i_cmd.col};
    assign addr_b  = (r_state == ST_RUN) ? {r_k, r_j}   : {i_cmd.row, i_cmd.col};

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_a_mem[addr_a] <= i_cmd.value;
        end
        r_rd_a <= r_a_mem[addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            r_b_mem[addr_b] <= i_cmd.value;
        end
        r_rd_b <= r_b_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_s1    <= '0;
            r_s2    <= '0;
        end else begin
            r_state <= n_state;
            r_s1    <= n_tag;
            r_s2    <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_k    <= n_k;
        r_j    <= n_j;
        r_prod <= r_rd_a * r_rd_b;
        if (r_s2.valid) begin
            r_acc <= n_acc;
        end
    end

    // accumulate stage and result forming
    assign n_acc = (r_s2.first ? '0 : r_acc) + rbmm_pkg::SUM_W'(r_prod);
    assign push  = r_s2.valid && (r_s2.lastk || r_s2.reject);

    always_comb begin
        n_res.row      = r_s2.row;
        n_res.col      = r_s2.col;
        n_res.sum      = r_s2.reject ? '0 : n_acc;
        n_res.last     = r_s2.reject || (r_s2.col == IDX_MAX);
        n_res.rejected = r_s2.reject;
    end

    assign out_pop        = o_result_valid && i_result_ready;
    assign o_result_valid = (r_ocnt != '0);
    assign o_result       = r_ofifo[r_ord];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ofifo[r_owr] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
            r_pend <= '0;
        end else begin
            if (push) begin
                r_owr <= r_owr + 1'b1;
            end
            if (out_pop) begin
                r_ord <= r_ord + 1'b1;
            end
            r_ocnt <= r_ocnt + {{rbmm_pkg::OPTR_W{1'b0}}, push}
                             - {{rbmm_pkg::OPTR_W{1'b0}}, out_pop};
            r_pend <= r_pend + {{rbmm_pkg::OPTR_W{1'b0}}, reserve}
                             - {{rbmm_pkg::OPTR_W{1'b0}}, out_pop};
        end
    end

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= OCNT_FULL)
        else $error("result reservations exceed queue depth");

    a_fill_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= r_pend)
        else $error("result queue holds an unreserved beat");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_ocnt != OCNT_FULL) || out_pop)
        else $error("result queue overflow");

    a_no_pop_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !o_cmd_pop)
        else $error("command popped during row compute");

endmodule
